>>> design/spq_pkg.sv
package spq_pkg;

   localparam int DEPTH          = 64;
   localparam int PRIORITY_WIDTH = 16;
   localparam int PAYLOAD_WIDTH  = 64;
   localparam int COUNT_WIDTH    = $clog2(DEPTH + 1);
   localparam int CAP_WIDTH      = 7;
   localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(64);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SERVE  = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_SERVED   = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic                      opcode;
      logic [PRIORITY_WIDTH-1:0] priority_req;
      logic [PAYLOAD_WIDTH-1:0]  payload;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic [PRIORITY_WIDTH-1:0] served_priority;
      logic [PAYLOAD_WIDTH-1:0]  served_payload;
      logic [COUNT_WIDTH-1:0]    count;
   } rsp_type;

   typedef struct packed {
      logic [PRIORITY_WIDTH-1:0] prio;
      logic [PAYLOAD_WIDTH-1:0]  payload;
   } entry_type;

   // broadcast to every cell
   typedef struct packed {
      logic      insert;
      logic      serve;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

>>> design/sorted_priority_queue_top.sv
// Sorted priority queue, up to 64 entries. A request (insert or serve) is taken
// on any cycle with start high; busy never rises, so one request per cycle is
// sustained. Its response appears on rsp_data with rsp_valid high for exactly
// one cycle, on the cycle after the request, and cannot be held off. Entries
// live in a row of cells ordered from highest priority at cell 0; each request
// shifts the row by at most one place, so throughput is one
// request per clock. Equal priorities leave in arrival order. Inserts are
// refused while the count is at or above min(capacity, 64). The csr channel is
// always ready; capacity should change only with no request in flight.
module sorted_priority_queue_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  spq_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   output spq_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [spq_pkg::CAP_WIDTH-1:0]      csr_data
);
   import spq_pkg::*;

   logic [CAP_WIDTH-1:0]   cap_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   cell_ctrl_type          ctrl;
   logic [DEPTH-1:0]       occupied;
   logic [DEPTH-1:0]       ge;
   entry_type              entries [DEPTH];

   logic                   accept;
   logic                   full;
   logic                   empty;
   logic [COUNT_WIDTH-1:0] eff_cap;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   assign eff_cap = (32'(cap_ff) > DEPTH) ? COUNT_WIDTH'(DEPTH)
                                          : COUNT_WIDTH'(cap_ff);
   assign full    = count_ff >= eff_cap;
   assign empty   = count_ff == '0;

   assign ctrl.insert    = accept && (req_data.opcode == OP_INSERT) && !full;
   assign ctrl.serve     = accept && (req_data.opcode == OP_SERVE) && !empty;
   assign ctrl.new_entry = '{prio: req_data.priority_req, payload: req_data.payload};

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         entry_type prev_e;
         entry_type next_e;
         logic      prev_g;

         assign occupied[i] = 32'(count_ff) > i;

         if (i == 0) begin : g_head
            assign prev_g = 1'b1;
            assign prev_e = '0;
         end else begin : g_body
            assign prev_g = ge[i-1];
            assign prev_e = entries[i-1];
         end

         if (i == DEPTH - 1) begin : g_tail
            assign next_e = '0;
         end else begin : g_mid
            assign next_e = entries[i+1];
         end

         spq_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occupied   (occupied[i]),
            .prev_ge    (prev_g),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .ge         (ge[i]),
            .entry      (entries[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      rsp_in   = '0;
      if (req_data.opcode == OP_INSERT) begin
         if (full) begin
            rsp_in.status = ST_FULL;
         end else begin
            rsp_in.status = ST_INSERTED;
            count_in      = count_ff + COUNT_WIDTH'(1);
         end
      end else begin
         if (empty) begin
            rsp_in.status = ST_EMPTY;
         end else begin
            rsp_in.status          = ST_SERVED;
            rsp_in.served_priority = entries[0].prio;
            rsp_in.served_payload  = entries[0].payload;
            count_in               = count_ff - COUNT_WIDTH'(1);
         end
      end
      rsp_in.count = count_in;
      if (!accept) begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> design/spq_cell.sv
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                  occupied,
   input  logic                  prev_ge,
   input  spq_pkg::entry_type    prev_entry,
   input  spq_pkg::entry_type    next_entry,
   output logic                  ge,
   output spq_pkg::entry_type    entry
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // stays in place when it outranks or ties the new entry
   assign ge    = occupied && (entry_ff.prio >= ctrl.new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert && !ge) begin
         entry_in = prev_ge ? ctrl.new_entry : prev_entry;
      end else if (ctrl.serve) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
   import spq_pkg::*;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CAP_WIDTH-1:0] csr_data;

   // shadow copy of the queue: slot 0 lowest, slot held_count-1 served next
   logic [PRIORITY_WIDTH-1:0] held_prio [DEPTH];
   logic [PAYLOAD_WIDTH-1:0] held_payload [DEPTH];
   int held_count;
   int cap_setting;

   rsp_type outcomes_due[$];
   int mismatch_count;
   int gap_pct;

   sorted_priority_queue_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type queue_outcome(input req_type r);
      rsp_type o;
      int slot;
      int lim;
      o = '0;
      lim = (cap_setting > DEPTH) ? DEPTH : cap_setting;
      if (r.opcode == OP_INSERT) begin
         if (held_count >= lim) begin
            o.status = ST_FULL;
         end else begin
            slot = 0;
            // new entry goes below every equal priority already held
            while (slot < held_count && held_prio[slot] < r.priority_req)
               slot++;
            for (int i = held_count; i > slot; i--) begin
               held_prio[i] = held_prio[i-1];
               held_payload[i] = held_payload[i-1];
            end
            held_prio[slot] = r.priority_req;
            held_payload[slot] = r.payload;
            held_count++;
            o.status = ST_INSERTED;
         end
      end else begin
         if (held_count == 0) begin
            o.status = ST_EMPTY;
         end else begin
            held_count--;
            o.served_priority = held_prio[held_count];
            o.served_payload = held_payload[held_count];
            o.status = ST_SERVED;
         end
      end
      o.count = COUNT_WIDTH'(held_count);
      return o;
   endfunction

   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (outcomes_due.size() == 0) begin
            $display("%0t: response with none expected, expected none actual %h",
                     $time, rsp_data);
            mismatch_count++;
         end else begin
            want = outcomes_due.pop_front();
            compare_field("status", 64'(want.status), 64'(rsp_data.status));
            compare_field("served_priority", 64'(want.served_priority),
                          64'(rsp_data.served_priority));
            compare_field("served_payload", 64'(want.served_payload),
                          64'(rsp_data.served_payload));
            compare_field("count", 64'(want.count), 64'(rsp_data.count));
         end
      end
   end

   task automatic send_req(input req_type r);
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      outcomes_due.push_back(queue_outcome(r));
   endtask

   task automatic pause_req(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_drained();
      pause_req(1);
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(input int value);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= CAP_WIDTH'(value);
      do @(posedge clock); while (!csr_ready);
      cap_setting = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_req(input logic op, input int prio,
                                        input logic [63:0] pay);
      req_type r;
      r.opcode = op;
      r.priority_req = PRIORITY_WIDTH'(prio);
      r.payload = pay;
      return r;
   endfunction

   function automatic req_type random_req(input int insert_pct, input bit narrow);
      req_type r;
      r.opcode = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_SERVE;
      // narrow mode crowds a few priorities so ties are common
      if (narrow)
         r.priority_req = ($urandom_range(3) == 0)
                          ? PRIORITY_WIDTH'(16'hFFFF - $urandom_range(1))
                          : PRIORITY_WIDTH'($urandom_range(3));
      else
         r.priority_req = PRIORITY_WIDTH'($urandom);
      r.payload = {$urandom, $urandom};
      return r;
   endfunction

   task automatic random_burst(input int n, input int insert_pct, input bit narrow);
      for (int i = 0; i < n; i++) begin
         if (gap_pct > 0 && $urandom_range(99) < gap_pct)
            pause_req(1);
         send_req(random_req(insert_pct, narrow));
      end
   endtask

   task automatic test_basic_order();
      send_req(make_req(OP_SERVE, 0, 64'h0));
      send_req(make_req(OP_INSERT, 0, 64'h0));
      send_req(make_req(OP_INSERT, 16'hFFFF, '1));
      send_req(make_req(OP_INSERT, 16'h1234, 64'hAAAA_AAAA_AAAA_AAAA));
      send_req(make_req(OP_INSERT, 16'h1234, 64'h5555_5555_5555_5555));
      send_req(make_req(OP_INSERT, 16'h1234, 64'h0123_4567_89AB_CDEF));
      repeat (6) send_req(make_req(OP_SERVE, 16'hFFFF, '1));
   endtask

   task automatic test_capacity_limits();
      write_capacity(0);
      send_req(make_req(OP_INSERT, 16'h8000, 64'h1));
      send_req(make_req(OP_SERVE, 0, 64'h0));
      write_capacity(2);
      repeat (3) send_req(make_req(OP_INSERT, $urandom, {$urandom, $urandom}));
      // drop below the current count: held entries stay servable
      write_capacity(1);
      send_req(make_req(OP_INSERT, 16'h7, 64'h7));
      send_req(make_req(OP_SERVE, 0, 64'h0));
      send_req(make_req(OP_INSERT, 16'h9, 64'h9));
      send_req(make_req(OP_SERVE, 0, 64'h0));
      send_req(make_req(OP_INSERT, 16'hB, 64'hB));
      send_req(make_req(OP_SERVE, 0, 64'h0));
   endtask

   task automatic test_fill_to_depth();
      // capacity above depth behaves as depth
      write_capacity(127);
      repeat (DEPTH + 2) send_req(random_req(100, 0));
      repeat (DEPTH + 2) send_req(random_req(0, 0));
   endtask

   task automatic test_random_mix();
      write_capacity(64);
      random_burst(100, 60, 0);
      wait_drained();
      random_burst(100, 60, 1);
      write_capacity(127);
      random_burst(100, 70, 1);
      write_capacity(64);
      gap_pct = 0;
      random_burst(100, 50, 1);
      gap_pct = 12;
      write_capacity(3);
      random_burst(80, 55, 0);
      write_capacity(10);
      random_burst(60, 80, 1);
      write_capacity(4);
      random_burst(60, 45, 1);
      write_capacity($urandom_range(127));
      random_burst(100, 55, 0);
      write_capacity(0);
      random_burst(20, 50, 0);
      write_capacity(64);
      random_burst(70, 20, 0);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      held_count = 0;
      cap_setting = int'(CAP_RESET);
      mismatch_count = 0;
      gap_pct = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_order();
      test_capacity_limits();
      test_fill_to_depth();
      gap_pct = 12;
      test_random_mix();

      wait_drained();
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
